/* hw/rtl/ktmp_pkg.sv */
// Package for the k-trade max profit stream block.
// Holds widths, the chain depth, the beat type passed between cells and the
// no-position constant. No dependencies.
`default_nettype none

package ktmp_pkg;

  localparam int MAX_TRADES = 8;
  localparam int PRICE_W    = 16;
  localparam int PROFIT_W   = 32;
  localparam int HOLD_W     = PROFIT_W + 1;
  localparam int SELL_W     = PROFIT_W + 2;
  localparam int LIMIT_W    = 4;
  localparam int CNT_W      = $clog2(MAX_TRADES + 1);

  // Most negative holding value: no position is open.
  localparam logic signed [HOLD_W-1:0] NO_POSITION = {1'b1, {PROFIT_W{1'b0}}};
  localparam logic [PROFIT_W-1:0]      PROFIT_CAP  = {PROFIT_W{1'b1}};

  // One beat as it travels down the chain of trade cells.
  typedef struct packed {
    logic                valid;
    logic [PRICE_W-1:0]  price;
    logic                start;
    logic [PROFIT_W-1:0] prev_profit;
    logic [CNT_W-1:0]    remain;
    logic [PROFIT_W-1:0] result;
  } beat_t;

endpackage

`default_nettype wire

/* hw/rtl/ktmp_if.sv */
// Channel interfaces for the k-trade max profit stream block: price input,
// profit output and the trade limit write channel. Depends on ktmp_pkg.
`default_nettype none

interface ktmp_in_if;
  import ktmp_pkg::*;
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] price;
  logic               series_start;
  modport source (output valid, price, series_start, input ready);
  modport sink   (input valid, price, series_start, output ready);
endinterface

interface ktmp_out_if;
  import ktmp_pkg::*;
  logic                valid;
  logic                ready;
  logic [PROFIT_W-1:0] best_profit;
  modport source (output valid, best_profit, input ready);
  modport sink   (input valid, best_profit, output ready);
endinterface

interface ktmp_cfg_if;
  import ktmp_pkg::*;
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] max_trades;
  modport source (output valid, max_trades, input ready);
  modport sink   (input valid, max_trades, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ktmp_cell.sv */
// One trade slot of the chain: keeps holding cash and realized profit for
// its slot and hands the updated profit to the next slot.
// Depends on ktmp_pkg.
`default_nettype none

module ktmp_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire ktmp_pkg::beat_t up,
  output ktmp_pkg::beat_t      dn
);
  import ktmp_pkg::*;

  logic signed [HOLD_W-1:0] hold_r, hold_nxt, hold_old, buy;
  logic [PROFIT_W-1:0]      real_r, real_nxt, real_old;
  logic signed [SELL_W-1:0] sell, sell_sat;
  beat_t                    dn_r, dn_nxt;

  always_comb begin
    hold_old = up.start ? NO_POSITION : hold_r;
    real_old = up.start ? '0 : real_r;
    buy = $signed({1'b0, up.prev_profit}) -
          $signed({{(HOLD_W-PRICE_W){1'b0}}, up.price});
    hold_nxt = (buy > hold_old) ? buy : hold_old;
    sell = $signed({hold_nxt[HOLD_W-1], hold_nxt}) +
           $signed({{(SELL_W-PRICE_W){1'b0}}, up.price});
    sell_sat = (sell > $signed({2'b00, PROFIT_CAP})) ? $signed({2'b00, PROFIT_CAP}) : sell;
    real_nxt = (sell_sat > $signed({2'b00, real_old})) ? sell_sat[PROFIT_W-1:0] : real_old;

    dn_nxt             = up;
    dn_nxt.prev_profit = real_nxt;
    dn_nxt.remain      = (up.remain != '0) ? up.remain - 1'b1 : '0;
    // The slot that matches the trade limit drops its profit into the beat.
    dn_nxt.result      = (up.remain == CNT_W'(1)) ? real_nxt : up.result;
  end

  // Only the valid bit of the outgoing beat needs a reset; the payload is
  // ignored while valid is low.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r     <= NO_POSITION;
      real_r     <= '0;
      dn_r.valid <= 1'b0;
    end else if (adv) begin
      if (up.valid) begin
        hold_r <= hold_nxt;
        real_r <= real_nxt;
      end
      dn_r <= dn_nxt;
    end
  end

  assign dn = dn_r;

endmodule

`default_nettype wire

/* hw/rtl/k_trade_max_profit_stream.sv */
// Top level of the k-trade max profit stream block: a skewed chain of trade
// slot cells fed by the price channel. Depends on ktmp_pkg, ktmp_if, ktmp_cell.
`default_nettype none

// The block takes one price beat per cycle while the output is not stalled
// and returns, for each one, the best profit reachable with at most
// max_trades buy-sell pairs over the series so far, saturated at the 32-bit
// maximum. A beat with series_start set clears every slot before its price is
// used. The prices travel down a chain of MAX_TRADES identical cells, one per
// trade slot; each cell updates its slot and hands the new profit to its
// neighbor through its registered beat. The last cell's register is the output
// register. The whole chain holds while a result waits to be taken, so
// in_ch.ready follows out_ch.ready whenever a result is pending. The user
// must write the trade limit on the cfg channel only while the block is idle;
// the block does not enforce this. A limit of zero gives zero and a limit
// above MAX_TRADES is treated as MAX_TRADES.

module k_trade_max_profit_stream (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ktmp_in_if.sink     in_ch,
  ktmp_out_if.source  out_ch,
  ktmp_cfg_if.sink    cfg_ch
);
  import ktmp_pkg::*;

  logic [LIMIT_W-1:0] max_trades_r;
  logic [CNT_W-1:0]   limit;
  logic               adv;
  beat_t              stage [0:MAX_TRADES];

  // Trade limit register; writes are always taken.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_trades_r <= LIMIT_W'(1);
    end else if (cfg_ch.valid) begin
      max_trades_r <= cfg_ch.max_trades;
    end
  end

  // The countdown in each beat picks the slot whose profit is reported.
  assign limit = (int'(max_trades_r) > MAX_TRADES) ? CNT_W'(MAX_TRADES)
                                                     : CNT_W'(max_trades_r);

  // The chain moves when the output register is empty or being emptied.
  assign adv         = !stage[MAX_TRADES].valid || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    stage[0].valid       = in_ch.valid;
    stage[0].price       = in_ch.price;
    stage[0].start       = in_ch.series_start;
    stage[0].prev_profit = '0;
    stage[0].remain      = limit;
    stage[0].result      = '0;
  end

  for (genvar t = 0; t < MAX_TRADES; t++) begin : g_cell
    ktmp_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .up    (stage[t]),
      .dn    (stage[t+1])
    );
  end

  assign out_ch.valid       = stage[MAX_TRADES].valid;
  assign out_ch.best_profit = stage[MAX_TRADES].result;

endmodule

`default_nettype wire

/* verif/k_trade_max_profit_stream_tb.sv */
// Self-checking testbench for the k-trade max profit stream block: price beats
// in, best profit beats out, trade limit writes, all checked against a local
// model of the per-trade slots. Depends on ktmp_pkg, ktmp_if and the block.
`default_nettype none

module k_trade_max_profit_stream_tb;
  import ktmp_pkg::*;

  // Longest stretch without any handshake before the run is declared hung.
  // The worst honest stretch is the receiver hold-off or a long
  // run of random receiver stalls, both far below this.
  localparam int QUIET_LIMIT = 2000;
  // Cycles to linger after the last expected result, to catch stray beats.
  localparam int TAIL_CYCLES = MAX_TRADES + 4;
  localparam logic [LIMIT_W-1:0] LIMIT_AT_RESET = 1;
  localparam logic [PRICE_W-1:0] PRICE_TOP = {PRICE_W{1'b1}};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ktmp_in_if  in_ch();
  ktmp_out_if out_ch();
  ktmp_cfg_if cfg_ch();

  k_trade_max_profit_stream dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #6 clk = ~clk;

  // Local copy of the slot state. best_holding is the best cash while a
  // position from the (t+1)-th buy is open; best_realized is the best profit with
  // at most t+1 finished trades.
  logic [PROFIT_W-1:0]      best_realized [MAX_TRADES];
  logic signed [HOLD_W-1:0] best_holding  [MAX_TRADES];
  logic [LIMIT_W-1:0]       trade_limit;
  logic [PROFIT_W-1:0]      profit_q [$];
  logic [PROFIT_W-1:0]      want_profit;

  int fail_count   = 0;
  int in_gap_pct   = 0;
  int out_gap_pct  = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  function automatic void wipe_slots();
    for (int t = 0; t < MAX_TRADES; t++) begin
      best_realized[t] = '0;
      best_holding[t]  = NO_POSITION;
    end
  endfunction

  // Applies one price to every slot in ascending order and returns the best
  // profit at the current trade limit. Each slot may buy with the profit the
  // slot below has just reached, then sell at the same price; a same-price
  // round trip gains nothing, so it never changes the answer.
  function automatic logic [PROFIT_W-1:0] advance_slots(input logic [PRICE_W-1:0] price,
                                                        input logic start);
    longint carry;
    longint buy;
    longint sell;
    int     lim;
    if (start) begin
      wipe_slots();
    end
    carry = 0;
    for (int t = 0; t < MAX_TRADES; t++) begin
      buy = carry - longint'(price);
      if (buy > longint'(best_holding[t])) begin
        best_holding[t] = HOLD_W'(buy);
      end
      sell = longint'(best_holding[t]) + longint'(price);
      // With 16-bit prices the cap is out of reach, but the block saturates.
      if (sell > longint'(PROFIT_CAP)) begin
        sell = longint'(PROFIT_CAP);
      end
      if (sell > longint'(best_realized[t])) begin
        best_realized[t] = PROFIT_W'(sell);
      end
      carry = longint'(best_realized[t]);
    end
    // A limit above the chain depth reads the deepest slot; zero allows no trade.
    lim = (trade_limit > MAX_TRADES) ? MAX_TRADES : int'(trade_limit);
    return (lim == 0) ? '0 : best_realized[lim-1];
  endfunction

  // Scoreboard: limit writes, result checks and predictions all happen here,
  // in that order, so a result is never compared with the prediction made at
  // the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      trade_limit = LIMIT_AT_RESET;
      wipe_slots();
      profit_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        trade_limit = cfg_ch.max_trades;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (profit_q.size() == 0) begin
          if (fail_count < 10) begin
            $display("best_profit beat with nothing expected: got %0d", out_ch.best_profit);
          end
          fail_count++;
        end else begin
          want_profit = profit_q.pop_front();
          if (out_ch.best_profit !== want_profit) begin
            if (fail_count < 10) begin
              $display("best_profit mismatch: expected %0d, got %0d",
                       want_profit, out_ch.best_profit);
            end
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        profit_q.push_back(advance_slots(in_ch.price, in_ch.series_start));
      end
    end
  end

  // Result side: random stalls, or a solid hold-off while hold_left runs down.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= out_gap_pct);
    end
  end

  // Watchdog: any handshake restarts the count.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("k_trade_max_profit_stream_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one price beat, after a random gap, and returns at the edge where it
  // is taken. Valid is left high so back-to-back beats need no extra edge.
  task automatic send_price(input logic [PRICE_W-1:0] price, input logic start);
    if ($urandom_range(0, 99) < in_gap_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < in_gap_pct);
    end
    in_ch.valid        <= 1'b1;
    in_ch.price        <= price;
    in_ch.series_start <= start;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops offering and waits until every predicted result has been checked.
  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (profit_q.size() != 0);
  endtask

  // The limit is only changed with the chain empty.
  task automatic write_limit(input logic [LIMIT_W-1:0] limit);
    wait_all_results();
    repeat (2) @(posedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.max_trades <= limit;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // One series with a random price shape: full-range noise, a drifting walk,
  // the two rail values, or tiny prices full of ties.
  task automatic send_series(input int len);
    int                 shape;
    int                 level;
    logic [PRICE_W-1:0] price;
    logic               start;
    shape = $urandom_range(0, 3);
    level = $urandom_range(0, 65535);
    for (int i = 0; i < len; i++) begin
      case (shape)
        0: price = PRICE_W'($urandom_range(0, 65535));
        1: begin
          level = level + int'($urandom_range(0, 2000)) - 1000;
          if (level < 0) begin
            level = 0;
          end else if (level > 65535) begin
            level = 65535;
          end
          price = PRICE_W'(level);
        end
        2: price = ($urandom_range(0, 1) != 0) ? PRICE_TOP : '0;
        default: price = PRICE_W'($urandom_range(0, 15));
      endcase
      // The first beat opens the series; a rare stray start mid-series is noise.
      start = (i == 0) || ($urandom_range(0, 29) == 0);
      send_price(price, start);
    end
  endtask

  // Limit of one straight out of reset, with rail prices.
  task automatic test_default_limit();
    in_gap_pct  = 0;
    out_gap_pct = 0;
    send_price(PRICE_TOP, 1'b1);
    send_price('0, 1'b0);
    send_price('0, 1'b0);
    send_price(PRICE_TOP, 1'b0);
  endtask

  // Two profitable swings, so one trade and several trades differ. Zero must
  // give nothing; nine and fifteen must read the deepest slot like eight.
  task automatic test_limit_range();
    logic [LIMIT_W-1:0] limits [4];
    limits = '{4'd0, 4'd8, 4'd9, 4'd15};
    foreach (limits[i]) begin
      write_limit(limits[i]);
      send_price('0, 1'b1);
      send_price(PRICE_TOP, 1'b0);
      send_price('0, 1'b0);
      send_price(PRICE_TOP, 1'b0);
    end
  endtask

  // The limit changes in the middle of a series. The sender pauses until the
  // chain is empty, the limit goes from one to two, and the series goes on
  // without a start, so the answer must come from the deeper slot at once.
  task automatic test_limit_mid_series();
    write_limit(LIMIT_W'(1));
    send_price(16'd10, 1'b1);
    send_price(16'd500, 1'b0);
    send_price(16'd20, 1'b0);
    send_price(16'd900, 1'b0);
    write_limit(LIMIT_W'(2));
    send_price(16'd30, 1'b0);
    send_price(PRICE_TOP, 1'b0);
  endtask

  // The receiver holds off for a long stretch while prices keep coming, so the
  // chain fills and the input stalls until the results drain.
  task automatic test_receiver_hold();
    write_limit(LIMIT_W'(MAX_TRADES));
    in_gap_pct  = 0;
    out_gap_pct = 0;
    hold_left <= 60;
    send_series(40);
  endtask

  // Random series under one idling profile, with a new limit every 90 beats
  // or so: mostly in range, sometimes zero or above the chain depth.
  task automatic test_random_traffic(input int send_idle, input int take_idle, input int beats);
    int sent;
    int seg_end;
    int len;
    in_gap_pct  = send_idle;
    out_gap_pct = take_idle;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(0, 3) == 0) begin
        write_limit(LIMIT_W'($urandom_range(0, 15)));
      end else begin
        write_limit(LIMIT_W'($urandom_range(1, MAX_TRADES)));
      end
      seg_end = sent + 90;
      while (sent < seg_end && sent < beats) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 15);
        send_series(len);
        sent += len;
      end
    end
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.price        = '0;
    in_ch.series_start = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.max_trades  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_default_limit();
    test_limit_range();
    test_limit_mid_series();
    test_receiver_hold();
    test_random_traffic(7, 77, 267);
    test_random_traffic(77, 7, 267);
    test_random_traffic(0, 0, 267);

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("k_trade_max_profit_stream_tb OK");
    end else begin
      $display("k_trade_max_profit_stream_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
